>>> rtl/rmq_pkg.sv
// Shared types and constants of the rotation matrix to quaternion unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int NUM_W     = IN_W + 1;
    localparam int ARG_W     = IN_W + 1;
    localparam int RAD_W     = ((ARG_W + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_PER    = 2;
    localparam int SQ_STG    = ROOT_W / SQ_PER;
    localparam int S_W       = ROOT_W + 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DVD_W     = NUM_W - 1 + FRAC_BITS + 1;
    localparam int DV_PER    = 3;
    localparam int DV_STG    = Q_W / DV_PER;
    localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    // Numerators of the three divided components, in output order with the
    // branch's own component left out.
    typedef struct packed {
        t_branch                    br;
        logic [2:0][NUM_W-1:0]      num;
    } t_side;

endpackage
`default_nettype wire

>>> rtl/rmq_prep.sv
// Branch choice, square root argument and numerators from the matrix.
// Combinational; uses rmq_pkg.
`default_nettype none
module rmq_prep import rmq_pkg::*; (
    input  wire logic signed [IN_W-1:0] i_r00,
    input  wire logic signed [IN_W-1:0] i_r01,
    input  wire logic signed [IN_W-1:0] i_r02,
    input  wire logic signed [IN_W-1:0] i_r10,
    input  wire logic signed [IN_W-1:0] i_r11,
    input  wire logic signed [IN_W-1:0] i_r12,
    input  wire logic signed [IN_W-1:0] i_r20,
    input  wire logic signed [IN_W-1:0] i_r21,
    input  wire logic signed [IN_W-1:0] i_r22,
    output      logic [ARG_W-1:0]       o_arg,
    output      t_side                  o_side
);
    localparam int T_W = IN_W + 3;

    logic signed [T_W-1:0]   tr, arg, one_s;
    logic signed [T_W-1:0]   a00, a11, a22;
    logic signed [NUM_W-1:0] d_x, d_y, d_z, s01, s02, s12;

    always_comb begin
        a00   = T_W'(i_r00);
        a11   = T_W'(i_r11);
        a22   = T_W'(i_r22);
        one_s = T_W'(ONE);
        tr    = a00 + a11 + a22;
        d_x   = NUM_W'(i_r21) - NUM_W'(i_r12);
        d_y   = NUM_W'(i_r02) - NUM_W'(i_r20);
        d_z   = NUM_W'(i_r10) - NUM_W'(i_r01);
        s01   = NUM_W'(i_r01) + NUM_W'(i_r10);
        s02   = NUM_W'(i_r02) + NUM_W'(i_r20);
        s12   = NUM_W'(i_r12) + NUM_W'(i_r21);
        if (tr > 0) begin
            o_side.br  = BR_W;
            arg        = one_s + tr;
            o_side.num = {d_z, d_y, d_x};
        end else if (i_r00 > i_r11 && i_r00 > i_r22) begin
            o_side.br  = BR_X;
            arg        = one_s + a00 - a11 - a22;
            o_side.num = {s02, s01, d_x};
        end else if (i_r11 > i_r22) begin
            o_side.br  = BR_Y;
            arg        = one_s + a11 - a00 - a22;
            o_side.num = {s12, s01, d_y};
        end else begin
            o_side.br  = BR_Z;
            arg        = one_s + a22 - a00 - a11;
            o_side.num = {s12, s02, d_z};
        end
        // A matrix that is not a rotation can drive the argument negative.
        o_arg = (arg < 0) ? '0 : arg[ARG_W-1:0];
    end
endmodule
`default_nettype wire

>>> rtl/rmq_sqrt.sv
// Pipelined digit-by-digit integer square root, two result bits per stage.
// Carries the side data of each item along; uses rmq_pkg.
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [ARG_W-1:0]  i_arg,
    input  wire t_side             i_side,
    output      logic              o_valid,
    output      logic [ROOT_W-1:0] o_root,
    output      t_side             o_side
);
    localparam int REM_W = ROOT_W + 2;

    logic              r_vld  [SQ_STG+1];
    logic [RAD_W-1:0]  r_rad  [SQ_STG+1];
    logic [REM_W-1:0]  r_rem  [SQ_STG+1];
    logic [ROOT_W-1:0] r_root [SQ_STG+1];
    t_side             r_side [SQ_STG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rad[0]  <= RAD_W'({i_arg, {FRAC_BITS{1'b0}}});
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar g = 0; g < SQ_STG; g++) begin : g_stage
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        always_comb begin
            logic [REM_W+1:0] rem2;
            logic [REM_W+1:0] trial;
            n_rem  = r_rem[g];
            n_root = r_root[g];
            for (int k = 0; k < SQ_PER; k++) begin
                rem2  = {n_rem, r_rad[g][RAD_W-1-2*k -: 2]};
                trial = (REM_W+2)'({n_root, 2'b01});
                if (rem2 >= trial) begin
                    rem2   = rem2 - trial;
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
                n_rem = rem2[REM_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_rad[g+1]  <= r_rad[g] << (2 * SQ_PER);
            r_rem[g+1]  <= n_rem;
            r_root[g+1] <= n_root;
            r_side[g+1] <= r_side[g];
        end
    end

    assign o_valid = r_vld[SQ_STG];
    assign o_root  = r_root[SQ_STG];
    assign o_side  = r_side[SQ_STG];
endmodule
`default_nettype wire

>>> rtl/rmq_div.sv
// Three-lane pipelined restoring divider: numerator over S = 2 * root,
// rounded to nearest, saturated to one. Uses rmq_pkg.
`default_nettype none
module rmq_div import rmq_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [ROOT_W-1:0]      i_root,
    input  wire t_side                  i_side,
    output      logic                   o_valid,
    output      t_branch                o_br,
    output      logic [Q_W-1:0]         o_own,
    output      logic [2:0][IN_W-1:0]   o_q
);
    localparam int LO_W = Q_W;

    logic               r_vld  [DV_STG+1];
    t_branch            r_br   [DV_STG+1];
    logic [Q_W-1:0]     r_own  [DV_STG+1];
    logic [S_W-1:0]     r_s    [DV_STG+1];
    logic               r_zero [DV_STG+1];
    logic [2:0]         r_neg  [DV_STG+1];
    logic [2:0]         r_ovf  [DV_STG+1];
    logic [2:0][S_W-1:0]  r_rem [DV_STG+1];
    logic [2:0][LO_W-1:0] r_lo  [DV_STG+1];
    logic [2:0][Q_W-1:0]  r_q   [DV_STG+1];

    logic [S_W-1:0]       n_s;
    logic [Q_W-1:0]       n_own;
    logic [2:0]           n_neg, n_ovf;
    logic [2:0][S_W-1:0]  n_rem;
    logic [2:0][LO_W-1:0] n_lo;

    always_comb begin
        logic [S_W-1:0]       own_w;
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]     mag;
        logic [DVD_W-1:0]     dvd;
        n_s   = {i_root, 1'b0};
        own_w = (S_W'(i_root) + S_W'(1)) >> 1;
        n_own = (own_w > S_W'(ONE)) ? ONE : own_w[Q_W-1:0];
        for (int l = 0; l < 3; l++) begin
            num      = signed'(i_side.num[l]);
            n_neg[l] = num[NUM_W-1];
            mag      = n_neg[l] ? NUM_W'(-num) : NUM_W'(num);
            // Adding S/2 (the root) before the divide rounds to nearest.
            dvd      = DVD_W'({mag, {FRAC_BITS{1'b0}}}) + DVD_W'(i_root);
            n_ovf[l] = (DVD_W+1)'(dvd) >= (DVD_W+1)'({n_s, {Q_W{1'b0}}});
            n_rem[l] = S_W'(dvd[DVD_W-1:LO_W]);
            n_lo[l]  = dvd[LO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_br[0]   <= i_side.br;
        r_own[0]  <= n_own;
        r_s[0]    <= n_s;
        r_zero[0] <= (i_root == '0);
        r_neg[0]  <= n_neg;
        r_ovf[0]  <= n_ovf;
        r_rem[0]  <= n_rem;
        r_lo[0]   <= n_lo;
        r_q[0]    <= '0;
    end

    for (genvar g = 0; g < DV_STG; g++) begin : g_stage
        logic [2:0][S_W-1:0]  n_r;
        logic [2:0][LO_W-1:0] n_l;
        logic [2:0][Q_W-1:0]  n_q;

        always_comb begin
            logic [S_W:0] rem2;
            for (int l = 0; l < 3; l++) begin
                n_r[l] = r_rem[g][l];
                n_l[l] = r_lo[g][l];
                n_q[l] = r_q[g][l];
                for (int k = 0; k < DV_PER; k++) begin
                    rem2   = {n_r[l], n_l[l][LO_W-1]};
                    n_l[l] = n_l[l] << 1;
                    if (rem2 >= {1'b0, r_s[g]}) begin
                        rem2   = rem2 - {1'b0, r_s[g]};
                        n_q[l] = {n_q[l][Q_W-2:0], 1'b1};
                    end else begin
                        n_q[l] = {n_q[l][Q_W-2:0], 1'b0};
                    end
                    n_r[l] = rem2[S_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_br[g+1]   <= r_br[g];
            r_own[g+1]  <= r_own[g];
            r_s[g+1]    <= r_s[g];
            r_zero[g+1] <= r_zero[g];
            r_neg[g+1]  <= r_neg[g];
            r_ovf[g+1]  <= r_ovf[g];
            r_rem[g+1]  <= n_r;
            r_lo[g+1]   <= n_l;
            r_q[g+1]    <= n_q;
        end
    end

    always_comb begin
        logic [Q_W-1:0] mag;
        for (int l = 0; l < 3; l++) begin
            if (r_zero[DV_STG]) begin
                mag = '0;
            end else if (r_ovf[DV_STG][l] || r_q[DV_STG][l] > ONE) begin
                mag = ONE;
            end else begin
                mag = r_q[DV_STG][l];
            end
            o_q[l] = r_neg[DV_STG][l] ? IN_W'(-IN_W'(mag)) : IN_W'(mag);
        end
    end

    assign o_valid = r_vld[DV_STG];
    assign o_br    = r_br[DV_STG];
    assign o_own   = r_own[DV_STG];
endmodule
`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to unit quaternion, Q2.14 in and out, fully pipelined.
// Path to o_strobe: root stages, divider stages, then one output register;
// the first root stage loads at the accepting edge.
// Throughput: one item per cycle; busy is always low and the receiver cannot
// stall the output.
// Synchronous active-low reset clears all valid bits; data is not reset.
`default_nettype none
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output      logic                   busy,
    input  wire logic signed [IN_W-1:0] i_r00,
    input  wire logic signed [IN_W-1:0] i_r01,
    input  wire logic signed [IN_W-1:0] i_r02,
    input  wire logic signed [IN_W-1:0] i_r10,
    input  wire logic signed [IN_W-1:0] i_r11,
    input  wire logic signed [IN_W-1:0] i_r12,
    input  wire logic signed [IN_W-1:0] i_r20,
    input  wire logic signed [IN_W-1:0] i_r21,
    input  wire logic signed [IN_W-1:0] i_r22,
    output      logic                   o_strobe,
    output      logic signed [IN_W-1:0] o_qw,
    output      logic signed [IN_W-1:0] o_qx,
    output      logic signed [IN_W-1:0] o_qy,
    output      logic signed [IN_W-1:0] o_qz
);
    logic [ARG_W-1:0]     p_arg;
    t_side                p_side;
    logic                 sq_vld;
    logic [ROOT_W-1:0]    sq_root;
    t_side                sq_side;
    logic                 dv_vld;
    t_branch              dv_br;
    logic [Q_W-1:0]       dv_own;
    logic [2:0][IN_W-1:0] dv_q;
    logic [IN_W-1:0]      own;
    logic                 r_strobe;
    logic [IN_W-1:0]      r_qw, r_qx, r_qy, r_qz;

    assign busy = 1'b0;

    rmq_prep u_prep (
        .i_r00(i_r00), .i_r01(i_r01), .i_r02(i_r02),
        .i_r10(i_r10), .i_r11(i_r11), .i_r12(i_r12),
        .i_r20(i_r20), .i_r21(i_r21), .i_r22(i_r22),
        .o_arg(p_arg), .o_side(p_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(start && !busy), .i_arg(p_arg), .i_side(p_side),
        .o_valid(sq_vld), .o_root(sq_root), .o_side(sq_side)
    );

    rmq_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(sq_vld), .i_root(sq_root), .i_side(sq_side),
        .o_valid(dv_vld), .o_br(dv_br), .o_own(dv_own), .o_q(dv_q)
    );

    assign own = IN_W'(dv_own);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dv_vld;
        end
        case (dv_br)
            BR_W: begin
                r_qw <= own;     r_qx <= dv_q[0]; r_qy <= dv_q[1]; r_qz <= dv_q[2];
            end
            BR_X: begin
                r_qw <= dv_q[0]; r_qx <= own;     r_qy <= dv_q[1]; r_qz <= dv_q[2];
            end
            BR_Y: begin
                r_qw <= dv_q[0]; r_qx <= dv_q[1]; r_qy <= own;     r_qz <= dv_q[2];
            end
            default: begin
                r_qw <= dv_q[0]; r_qx <= dv_q[1]; r_qy <= dv_q[2]; r_qz <= own;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_qw     = r_qw;
    assign o_qx     = r_qx;
    assign o_qy     = r_qy;
    assign o_qz     = r_qz;
endmodule
`default_nettype wire

>>> tb/rmq_checker.sv
// Checker for the rotation matrix to quaternion unit: predicts each quaternion
// from the accepted matrix and compares it with the strobed result.
// Depends on rmq_pkg for the field width, fraction bits and branch type.
module rmq_checker import rmq_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire logic                   busy,
    input  wire logic signed [IN_W-1:0] i_r00, i_r01, i_r02,
    input  wire logic signed [IN_W-1:0] i_r10, i_r11, i_r12,
    input  wire logic signed [IN_W-1:0] i_r20, i_r21, i_r22,
    input  wire logic                   o_strobe,
    input  wire logic signed [IN_W-1:0] o_qw, o_qx, o_qy, o_qz,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_branch_hits [4]
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [IN_W-1:0] t_fld;
    typedef struct {
        t_fld w, x, y, z;
    } t_quat;

    t_quat quat_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Divides by S, rounding to nearest with ties away from zero.
    function automatic longint div_by_s(longint num, longint s);
        longint unsigned mag, quo;
        if (s <= 0) return 0;
        mag = (num < 0 ? -num : num) << FRAC_BITS;
        quo = (mag + s / 2) / s;
        return num < 0 ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic t_fld clamp(longint v);
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (v > one) v = one;
        if (v < -one) v = -one;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_fld'(v);
    endfunction

    function automatic t_quat predict_quat(longint m00, longint m01, longint m02,
                                           longint m10, longint m11, longint m12,
                                           longint m20, longint m21, longint m22,
                                           output t_branch br);
        longint one, trace, arg, s, own;
        longint unsigned root;
        t_quat q;
        one = longint'(1) << FRAC_BITS;
        trace = m00 + m11 + m22;
        if (trace > 0) begin
            br = BR_W; arg = one + trace;
        end else if (m00 > m11 && m00 > m22) begin
            br = BR_X; arg = one + m00 - m11 - m22;
        end else if (m11 > m22) begin
            br = BR_Y; arg = one + m11 - m00 - m22;
        end else begin
            br = BR_Z; arg = one + m22 - m00 - m11;
        end
        if (arg < 0) arg = 0;
        root = int_sqrt(longint'(arg) << FRAC_BITS);
        s = 2 * root;
        own = (root + 1) >> 1;
        case (br)
            BR_W: begin
                q.w = clamp(own);
                q.x = clamp(div_by_s(m21 - m12, s));
                q.y = clamp(div_by_s(m02 - m20, s));
                q.z = clamp(div_by_s(m10 - m01, s));
            end
            BR_X: begin
                q.w = clamp(div_by_s(m21 - m12, s));
                q.x = clamp(own);
                q.y = clamp(div_by_s(m01 + m10, s));
                q.z = clamp(div_by_s(m02 + m20, s));
            end
            BR_Y: begin
                q.w = clamp(div_by_s(m02 - m20, s));
                q.x = clamp(div_by_s(m01 + m10, s));
                q.y = clamp(own);
                q.z = clamp(div_by_s(m12 + m21, s));
            end
            default: begin
                q.w = clamp(div_by_s(m10 - m01, s));
                q.x = clamp(div_by_s(m02 + m20, s));
                q.y = clamp(div_by_s(m12 + m21, s));
                q.z = clamp(own);
            end
        endcase
        return q;
    endfunction

    task automatic compare_field(string name, t_fld exp_v, t_fld act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
        foreach (o_branch_hits[k]) o_branch_hits[k] = 0;
    end

    always @(posedge i_clk) begin
        t_quat exp_q;
        t_branch br;
        if (i_rst_n) begin
            if (start && !busy) begin
                quat_q.push_back(predict_quat(i_r00, i_r01, i_r02, i_r10, i_r11,
                                              i_r12, i_r20, i_r21, i_r22, br));
                o_branch_hits[br]++;
            end
            if (o_strobe) begin
                o_results++;
                if (quat_q.size() == 0) begin
                    $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d",
                             $time, o_qw, o_qx, o_qy, o_qz);
                    o_errors++;
                end else begin
                    exp_q = quat_q.pop_front();
                    compare_field("qw", exp_q.w, o_qw);
                    compare_field("qx", exp_q.x, o_qx);
                    compare_field("qy", exp_q.y, o_qy);
                    compare_field("qz", exp_q.z, o_qz);
                end
            end
            o_pending = quat_q.size();
        end
    end
endmodule

>>> tb/tb.sv
// Top of the rotation matrix to quaternion testbench: clock, reset, stimulus
// and verdict. Depends on rmq_pkg, the unit and rmq_checker.
module tb;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 16;
    localparam int N_RANDOM = 1330;
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [IN_W-1:0] mat [9];
    logic o_strobe;
    logic signed [IN_W-1:0] o_qw, o_qx, o_qy, o_qz;
    int errors, pending, results;
    int branch_hits [4];
    int idle_cycles;
    int accepted;

    initial foreach (mat[k]) mat[k] = '0;

    always #5 i_clk = ~i_clk;

    rotation_matrix_to_quaternion_unit dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_r00(mat[0]), .i_r01(mat[1]), .i_r02(mat[2]),
        .i_r10(mat[3]), .i_r11(mat[4]), .i_r12(mat[5]),
        .i_r20(mat[6]), .i_r21(mat[7]), .i_r22(mat[8]),
        .o_strobe, .o_qw, .o_qx, .o_qy, .o_qz
    );

    rmq_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy,
        .i_r00(mat[0]), .i_r01(mat[1]), .i_r02(mat[2]),
        .i_r10(mat[3]), .i_r11(mat[4]), .i_r12(mat[5]),
        .i_r20(mat[6]), .i_r21(mat[7]), .i_r22(mat[8]),
        .o_strobe, .o_qw, .o_qx, .o_qy, .o_qz,
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_branch_hits(branch_hits)
    );

    // Watchdog: too many cycles in a row without an accepted item or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d idle cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Presents one matrix and holds it until accepted; start stays high when
    // the next item follows without a gap.
    task automatic send_matrix(input logic signed [IN_W-1:0] m [9], input int gap);
        foreach (m[k]) mat[k] <= m[k];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        accepted++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [IN_W-1:0] rand_entry(int mode);
        case (mode)
            0: return IN_W'($urandom_range(0, 32768) - 16384);
            1: return IN_W'($urandom);
            default: return IN_W'($urandom_range(0, 2048) - 1024);
        endcase
    endfunction

    // Builds a rotation about one axis, optionally with sign flips of axes,
    // so every branch is reached with consistent off-diagonal terms.
    task automatic make_rotation(output logic signed [IN_W-1:0] m [9]);
        real a, c, s;
        int ax, p, q, k;
        a = ($urandom_range(0, 62831) / 10000.0);
        c = $cos(a) * 16384.0;
        s = $sin(a) * 16384.0;
        ax = $urandom_range(0, 2);
        p = (ax + 1) % 3;
        q = (ax + 2) % 3;
        for (k = 0; k < 9; k++) m[k] = '0;
        m[ax*3+ax] = 16'sd16384;
        m[p*3+p] = IN_W'($rtoi(c));
        m[q*3+q] = IN_W'($rtoi(c));
        m[q*3+p] = IN_W'($rtoi(s));
        m[p*3+q] = -IN_W'($rtoi(s));
        // A half turn about one axis lands in the x, y or z branch.
        if ($urandom_range(0, 3) == 0) begin
            for (k = 0; k < 9; k++) m[k] = '0;
            m[0] = 16'sd16384; m[4] = -16'sd16384; m[8] = -16'sd16384;
            if (ax == 1) begin m[0] = -16'sd16384; m[4] = 16'sd16384; end
            if (ax == 2) begin m[0] = -16'sd16384; m[8] = 16'sd16384; end
        end
        for (k = 0; k < 9; k++)
            if ($urandom_range(0, 7) == 0) m[k] = m[k] + IN_W'($urandom_range(0, 64) - 32);
    endtask

    initial begin
        logic signed [IN_W-1:0] m [9];
        int n, k, mode, burst_left, waited;
        accepted = 0;
        idle_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, half turns, zero matrix, extremes and ties.
        for (n = 0; n < 20; n++) begin
            for (k = 0; k < 9; k++) m[k] = '0;
            case (n)
                0: begin m[0] = 16384; m[4] = 16384; m[8] = 16384; end
                1: begin m[0] = 16384; m[4] = -16384; m[8] = -16384; end
                2: begin m[0] = -16384; m[4] = 16384; m[8] = -16384; end
                3: begin m[0] = -16384; m[4] = -16384; m[8] = 16384; end
                4: ;
                5: for (k = 0; k < 9; k++) m[k] = 16'sh7fff;
                6: for (k = 0; k < 9; k++) m[k] = 16'sh8000;
                7: for (k = 0; k < 9; k++) m[k] = (k % 2) ? 16'sh7fff : 16'sh8000;
                8: for (k = 0; k < 9; k++) m[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
                9: for (k = 0; k < 9; k++) m[k] = 16384;
                10: for (k = 0; k < 9; k++) m[k] = -16384;
                11: begin m[0] = -16384; m[4] = -16384; m[8] = -16384; end
                12: begin m[0] = 100; m[4] = 100; m[8] = -200; m[1] = 5; end
                13: begin m[0] = 16384; m[4] = 16384; m[8] = -16384; end
                14: begin m[0] = -1; m[4] = -1; m[8] = -1; m[7] = 16'sh7fff; end
                15: begin m[0] = 1; m[1] = 16384; m[3] = 16384; end
                16: begin m[0] = 16'sh8000; m[4] = 16'sh8000; m[8] = 16'sh7fff; end
                17: begin m[0] = 16'sh7fff; m[4] = 16'sh7fff; m[8] = 16'sh7fff; end
                18: begin m[0] = 5; m[4] = 5; m[8] = -10; m[2] = 16'sh8000; end
                default: begin m[1] = 16'sh5555; m[5] = 16'shaaaa; m[6] = 16'sh0f0f; end
            endcase
            send_matrix(m, pick_gap(0));
        end

        // Random: mostly near-rotations, else uniform, wild or small entries.
        burst_left = 0;
        for (n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                make_rotation(m);
            end else begin
                for (k = 0; k < 9; k++) m[k] = rand_entry(mode - 6);
            end
            if (burst_left == 0 && $urandom_range(0, 19) == 0)
                burst_left = $urandom_range(20, 60);
            send_matrix(m, pick_gap(burst_left > 0));
            if (burst_left > 0) burst_left--;
        end
        start <= 1'b0;

        waited = 0;
        while (pending > 0 && waited < 4 * LATENCY + 100) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Sent %0d matrices, checked %0d quaternions", accepted, results);
        $display("Branches taken: w %0d, x %0d, y %0d, z %0d",
                 branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
        if (pending > 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
